FILE: hw/rtl/qrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, payload types and root kind codes of the quadratic root
// solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH  = 16;
  localparam int ROOT_WIDTH  = 32;

  localparam int SQRT_SHIFT  = 16;
  localparam int NEGB_SHIFT  = 8;
  localparam int QUOT_SHIFT  = 7;

  localparam int DISC_W      = 2 * COEF_WIDTH + 2;
  localparam int MAG_W       = 2 * COEF_WIDTH + 1;
  localparam int SQIN_W      = MAG_W + SQRT_SHIFT;
  localparam int SQRT_W      = (SQIN_W + 1) / 2;
  localparam int NEGB_W      = COEF_WIDTH + NEGB_SHIFT + 1;
  localparam int NUM_W       = ((NEGB_W > SQRT_W + 1) ? NEGB_W : SQRT_W + 1) + 1;
  localparam int DVD_W       = NUM_W - 1 + QUOT_SHIFT;
  localparam int DEN_W       = COEF_WIDTH;
  localparam int CMP_W       = ((DVD_W > ROOT_WIDTH) ? DVD_W : ROOT_WIDTH) + 1;

  typedef enum logic [1:0] {
    KIND_TWO     = 2'd0,
    KIND_DOUBLE  = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_DEGEN   = 2'd3
  } root_kind_e;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    root_kind_e                   root_kind;
    logic signed [ROOT_WIDTH-1:0] first_real;
    logic signed [ROOT_WIDTH-1:0] second_real;
    logic signed [ROOT_WIDTH-1:0] imag_part;
    logic                         saturated;
  } out_t;

  typedef struct packed {
    root_kind_e                   root_kind;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic        [MAG_W-1:0]      mag;
  } disc_t;

endpackage
`default_nettype wire

FILE: hw/rtl/qrs_disc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_disc
// Two-stage discriminant: products b*b and a*c, then d = b*b - 4ac, its
// magnitude and the root kind.
// ----------------------------------------------------------------------------
module qrs_disc import qrs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire in_t   coef_i,
  output logic       valid_o,
  output disc_t      disc_o
);

  logic                           p_vld_q;
  logic signed [COEF_WIDTH-1:0]   p_a_q, p_b_q;
  logic signed [2*COEF_WIDTH-1:0] bb_q, ac_q;
  logic                           d_vld_q;
  disc_t                          disc_d, disc_q;
  logic signed [DISC_W-1:0]       disc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= valid_i;
      d_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q  <= coef_i.coef_a;
      p_b_q  <= coef_i.coef_b;
      bb_q   <= (2*COEF_WIDTH)'(coef_i.coef_b) * (2*COEF_WIDTH)'(coef_i.coef_b);
      ac_q   <= (2*COEF_WIDTH)'(coef_i.coef_a) * (2*COEF_WIDTH)'(coef_i.coef_c);
      disc_q <= disc_d;
    end
  end

  always_comb begin
    disc          = DISC_W'(bb_q) - (DISC_W'(ac_q) <<< 2);
    disc_d.coef_a = p_a_q;
    disc_d.coef_b = p_b_q;
    disc_d.mag    = disc[DISC_W-1] ? MAG_W'(-disc) : MAG_W'(disc);
    if (p_a_q == '0) begin
      disc_d.root_kind = KIND_DEGEN;
    end else if (disc[DISC_W-1]) begin
      disc_d.root_kind = KIND_COMPLEX;
    end else if (disc == '0) begin
      disc_d.root_kind = KIND_DOUBLE;
    end else begin
      disc_d.root_kind = KIND_TWO;
    end
  end

  assign valid_o = d_vld_q;
  assign disc_o  = disc_q;

endmodule
`default_nettype wire

FILE: hw/rtl/qrs_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [SQIN_W-1:0] rad_i,
  output logic      [SQRT_W-1:0] root_o
);

  logic [SQIN_W-1:0] rem_q [SQRT_W];
  logic [SQIN_W-1:0] res_q [SQRT_W];

  for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
    localparam logic [SQIN_W-1:0] BitC = SQIN_W'(1) << (2 * (SQRT_W - 1 - k));
    logic [SQIN_W-1:0] rem_in, res_in, rem_d, res_d;
    logic [SQIN_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    always_comb begin
      trial = {1'b0, res_in} + {1'b0, BitC};
      if ({1'b0, rem_in} >= trial) begin
        rem_d = rem_in - res_in - BitC;
        res_d = (res_in >> 1) + BitC;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign root_o = res_q[SQRT_W-1][SQRT_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/qrs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DVD_W-1:0] dvd_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [DVD_W-1:0] quot_o
);

  logic [DEN_W-1:0] rem_q  [DVD_W];
  logic [DVD_W-1:0] work_q [DVD_W];
  logic [DEN_W-1:0] den_q  [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in, rem_d;
    logic [DVD_W-1:0] work_in, work_d;
    logic [DEN_W:0]   trial;
    logic             qbit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dvd_i;
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign work_in = work_q[k-1];
      assign den_in  = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, work_in[DVD_W-1]};
      qbit  = trial >= {1'b0, den_in};
      rem_d = qbit ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      work_d = {work_in[DVD_W-2:0], qbit};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        work_q[k] <= work_d;
        den_q[k]  <= den_in;
      end
    end
  end

  assign quot_o = work_q[DVD_W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/quadratic_root_solver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Roots of a*x^2 + b*x + c from signed Q8.8 coefficients, in saturated Q16.16.
// ----------------------------------------------------------------------------
// One coefficient set is taken every cycle unless the output stalls. Its result
// passes through the discriminant stages, the bit-per-stage square root, the
// numerator register, the three parallel bit-per-stage dividers and the
// saturation into the output register. A stall at the output freezes the whole
// pipeline; bubbles keep their place. An a of zero gives kind 3 with all root
// fields zero.
module quadratic_root_solver_top import qrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  typedef struct packed {
    root_kind_e                   root_kind;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
  } side_t;

  typedef struct packed {
    root_kind_e root_kind;
    logic [2:0] neg;
  } nside_t;

  function automatic logic [ROOT_WIDTH:0] sat_root(input logic [DVD_W-1:0] mag,
                                                   input logic neg);
    logic [CMP_W-1:0]      m, lim;
    logic [ROOT_WIDTH-1:0] v;
    logic                  s;
    m   = CMP_W'(mag);
    lim = neg ? (CMP_W'(1) << (ROOT_WIDTH - 1))
              : ((CMP_W'(1) << (ROOT_WIDTH - 1)) - CMP_W'(1));
    s   = m > lim;
    if (s) begin
      v = neg ? {1'b1, {(ROOT_WIDTH-1){1'b0}}} : {1'b0, {(ROOT_WIDTH-1){1'b1}}};
    end else begin
      v = neg ? ROOT_WIDTH'(-m) : ROOT_WIDTH'(m);
    end
    return {s, v};
  endfunction

  logic adv;

  logic  d_vld;
  disc_t d_res;

  logic              sq_vld_q  [SQRT_W];
  side_t             sq_side_q [SQRT_W];
  logic [SQRT_W-1:0] sq_root;

  logic                    n_vld_q;
  nside_t                  n_side_d, n_side_q;
  logic [DVD_W-1:0]        n_dvd_d [3];
  logic [DVD_W-1:0]        n_dvd_q [3];
  logic [DEN_W-1:0]        n_den_d, n_den_q;
  logic signed [NUM_W-1:0] negb, s_ext;
  logic signed [NUM_W-1:0] num [3];
  logic [NUM_W-1:0]        nmag [3];

  logic             dv_vld_q  [DVD_W];
  nside_t           dv_side_q [DVD_W];
  logic [DVD_W-1:0] quot [3];

  logic [ROOT_WIDTH:0] r0, r1, r2;
  out_t                out_d, out_q;
  logic                out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  qrs_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .coef_i  (in_data_i),
    .valid_o (d_vld),
    .disc_o  (d_res)
  );

  qrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({d_res.mag, {SQRT_SHIFT{1'b0}}}),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQRT_W; i++) sq_vld_q[i] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= d_vld;
      for (int i = 1; i < SQRT_W; i++) sq_vld_q[i] <= sq_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_side_q[0] <= '{root_kind: d_res.root_kind, coef_a: d_res.coef_a,
                        coef_b: d_res.coef_b};
      for (int i = 1; i < SQRT_W; i++) sq_side_q[i] <= sq_side_q[i-1];
    end
  end

  always_comb begin
    s_ext  = {{(NUM_W-SQRT_W){1'b0}}, sq_root};
    negb   = -(NUM_W'(sq_side_q[SQRT_W-1].coef_b) <<< NEGB_SHIFT);
    num[0] = (sq_side_q[SQRT_W-1].root_kind == KIND_TWO) ? negb + s_ext : negb;
    num[1] = (sq_side_q[SQRT_W-1].root_kind == KIND_TWO) ? negb - s_ext : negb;
    num[2] = (sq_side_q[SQRT_W-1].root_kind == KIND_COMPLEX) ? s_ext : '0;
    n_side_d.root_kind = sq_side_q[SQRT_W-1].root_kind;
    for (int i = 0; i < 3; i++) begin
      nmag[i]        = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
      n_dvd_d[i]     = {nmag[i][NUM_W-2:0], {QUOT_SHIFT{1'b0}}};
      n_side_d.neg[i] = num[i][NUM_W-1] ^ sq_side_q[SQRT_W-1].coef_a[COEF_WIDTH-1];
    end
    n_den_d = sq_side_q[SQRT_W-1].coef_a[COEF_WIDTH-1]
            ? DEN_W'(-sq_side_q[SQRT_W-1].coef_a)
            : DEN_W'(sq_side_q[SQRT_W-1].coef_a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (adv) begin
      n_vld_q <= sq_vld_q[SQRT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_side_q <= n_side_d;
      n_den_q  <= n_den_d;
      for (int i = 0; i < 3; i++) n_dvd_q[i] <= n_dvd_d[i];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    qrs_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .dvd_i  (n_dvd_q[l]),
      .den_i  (n_den_q),
      .quot_o (quot[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DVD_W; i++) dv_vld_q[i] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= n_vld_q;
      for (int i = 1; i < DVD_W; i++) dv_vld_q[i] <= dv_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= n_side_q;
      for (int i = 1; i < DVD_W; i++) dv_side_q[i] <= dv_side_q[i-1];
    end
  end

  always_comb begin
    r0 = sat_root(quot[0], dv_side_q[DVD_W-1].neg[0]);
    r1 = sat_root(quot[1], dv_side_q[DVD_W-1].neg[1]);
    r2 = sat_root(quot[2], dv_side_q[DVD_W-1].neg[2]);
    out_d.root_kind = dv_side_q[DVD_W-1].root_kind;
    if (dv_side_q[DVD_W-1].root_kind == KIND_DEGEN) begin
      out_d.first_real  = '0;
      out_d.second_real = '0;
      out_d.imag_part   = '0;
      out_d.saturated   = 1'b0;
    end else begin
      out_d.first_real  = r0[ROOT_WIDTH-1:0];
      out_d.second_real = r1[ROOT_WIDTH-1:0];
      out_d.imag_part   = r2[ROOT_WIDTH-1:0];
      out_d.saturated   = r0[ROOT_WIDTH] | r1[ROOT_WIDTH] | r2[ROOT_WIDTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_vld_q[DVD_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_kind == KIND_DEGEN |->
      out_data_o.first_real == '0 && out_data_o.second_real == '0 &&
      out_data_o.imag_part == '0 && !out_data_o.saturated)
    else $error("degenerate result with nonzero fields");

  a_imag_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_kind != KIND_COMPLEX |-> out_data_o.imag_part == '0)
    else $error("imaginary part on a real result");

  a_double_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_kind == KIND_DOUBLE |->
      out_data_o.first_real == out_data_o.second_real)
    else $error("double root halves differ");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("result dropped during stall");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_top
// Random and directed coefficient sets through the root solver; every result
// is checked in order against a software model of the fixed-point roots.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_top;
  import qrs_pkg::*;

  localparam int NUM_RANDOM = 1200;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [ROOT_WIDTH-1:0] clip_quot(longint num, longint den,
                                                             ref logic sat);
    longint hi;
    longint lo;
    longint q;
    hi = (64'sd1 <<< (ROOT_WIDTH - 1)) - 1;
    lo = -hi - 1;
    q  = (num * 128) / den;
    if (q > hi) begin
      q   = hi;
      sat = 1'b1;
    end else if (q < lo) begin
      q   = lo;
      sat = 1'b1;
    end
    return q[ROOT_WIDTH-1:0];
  endfunction

  function automatic out_t solve_roots(in_t s);
    out_t   r;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint negb;
    longint sq;
    logic   sat;
    a   = s.coef_a;
    b   = s.coef_b;
    c   = s.coef_c;
    sat = 1'b0;
    r   = '0;
    if (a == 0) begin
      r.root_kind = KIND_DEGEN;
      return r;
    end
    disc = b * b - 4 * a * c;
    sq   = int_sqrt((disc < 0 ? -disc : disc) << 16);
    negb = -b * 256;
    if (disc > 0) begin
      r.root_kind   = KIND_TWO;
      r.first_real  = clip_quot(negb + sq, a, sat);
      r.second_real = clip_quot(negb - sq, a, sat);
    end else if (disc == 0) begin
      r.root_kind   = KIND_DOUBLE;
      r.first_real  = clip_quot(negb, a, sat);
      r.second_real = r.first_real;
    end else begin
      r.root_kind   = KIND_COMPLEX;
      r.first_real  = clip_quot(negb, a, sat);
      r.second_real = r.first_real;
      r.imag_part   = clip_quot(sq, a, sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  int error_count = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  class root_scoreboard;
    out_t pending_roots[$];

    function void note_input(in_t s);
      pending_roots.push_back(solve_roots(s));
    endfunction

    task check_result(out_t got);
      out_t want;
      if (pending_roots.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending_roots.pop_front();
      if (got.root_kind !== want.root_kind) report("root_kind", got.root_kind, want.root_kind);
      if (got.first_real !== want.first_real)
        report("first_real", got.first_real, want.first_real);
      if (got.second_real !== want.second_real)
        report("second_real", got.second_real, want.second_real);
      if (got.imag_part !== want.imag_part) report("imag_part", got.imag_part, want.imag_part);
      if (got.saturated !== want.saturated) report("saturated", got.saturated, want.saturated);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  bit   stim_done;

  root_scoreboard roots_sb = new();

  quadratic_root_solver_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 70);
  endfunction

  task automatic send_set(in_t s);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    roots_sb.note_input(s);
  endtask

  task automatic send_coefs(int a, int b, int c);
    in_t s;
    s.coef_a = a[COEF_WIDTH-1:0];
    s.coef_b = b[COEF_WIDTH-1:0];
    s.coef_c = c[COEF_WIDTH-1:0];
    send_set(s);
  endtask

  function automatic logic [COEF_WIDTH-1:0] rand_coef();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) return COEF_WIDTH'($urandom);
    if (p < 7) return COEF_WIDTH'($urandom_range(0, 2047) - 1024);
    if (p < 8) return COEF_WIDTH'($urandom_range(0, 15) - 8);
    if (p < 9) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'h0000;
  endfunction

  task automatic send_random();
    in_t s;
    int  m;
    int  b;
    m        = $urandom_range(0, 9);
    s.coef_a = rand_coef();
    s.coef_b = rand_coef();
    s.coef_c = rand_coef();
    if (m == 0 && s.coef_a != 0) begin
      // double root: b even, c = b*b/(4a) when exact
      b        = 2 * ($urandom_range(0, 255) - 128);
      s.coef_a = COEF_WIDTH'($urandom_range(1, 4));
      s.coef_b = COEF_WIDTH'(b);
      if ((b * b) % (4 * s.coef_a) == 0) s.coef_c = COEF_WIDTH'((b * b) / (4 * s.coef_a));
      if ($urandom_range(0, 1)) begin
        s.coef_a = -s.coef_a;
        s.coef_c = -s.coef_c;
      end
    end
    send_set(s);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    stim_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_coefs(0, 100, -5);
    send_coefs(0, 0, 0);
    send_coefs(256, 0, -1024);
    send_coefs(256, -512, 256);
    send_coefs(256, 0, 256);
    send_coefs(-256, 512, 768);
    send_coefs(-256, 0, -256);
    send_coefs(1, 0, 0);
    send_coefs(32767, 32767, 32767);
    send_coefs(-32768, -32768, -32768);
    send_coefs(1, -32768, 32767);
    send_coefs(1, 32767, -32768);
    send_coefs(-1, -32768, -32768);
    send_coefs(-32768, 32767, 32767);
    send_coefs(32767, -32768, 0);
    send_coefs(1, 0, 32767);
    send_coefs(-1, 0, 32767);
    send_coefs(2, 4, 2);
    send_coefs(-32768, 0, 0);
    send_coefs(32767, 1, -1);
    for (int i = 0; i < NUM_RANDOM; i++) send_random();
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int g;
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) roots_sb.check_result(out_data);
  end

  initial begin
    wait (stim_done);
    while (roots_sb.pending_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_disc.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver_top.sv
tb/tb_quadratic_root_solver_top.sv
